FILE: rtl/core/hrp_pkg.sv
package hrp_pkg;

	// field kinds tagged on each byte
	localparam logic [2:0] KIND_METHOD   = 3'd0;
	localparam logic [2:0] KIND_URL      = 3'd1;
	localparam logic [2:0] KIND_PROTOCOL = 3'd2;
	localparam logic [2:0] KIND_HNAME    = 3'd3;
	localparam logic [2:0] KIND_HVALUE   = 3'd4;
	localparam logic [2:0] KIND_NONE     = 3'd5;

	// verdict codes
	localparam logic [2:0] ERR_NONE     = 3'd0;
	localparam logic [2:0] ERR_METHOD   = 3'd1;
	localparam logic [2:0] ERR_URL      = 3'd2;
	localparam logic [2:0] ERR_PROTOCOL = 3'd3;
	localparam logic [2:0] ERR_HLINE    = 3'd4;
	localparam logic [2:0] ERR_EMPTY    = 3'd5;
	localparam logic [2:0] ERR_TOO_MANY = 3'd6;

	// characters
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_SLASH = 8'h2F;

	localparam int GET_LEN   = 3;
	localparam int PROTO_LEN = 8;
	localparam logic [7:0] LIT_GET [GET_LEN] = '{8'h47, 8'h45, 8'h54};
	localparam logic [7:0] LIT_PROTO [PROTO_LEN] =
		'{8'h48, 8'h54, 8'h54, 8'h50, 8'h2F, 8'h31, 8'h2E, 8'h31};

	localparam int HDR_W = 7;
	localparam logic [HDR_W-1:0] HDR_SAT = 7'h7F;
	localparam int MAX_HEADERS_DEF = 127;
	localparam int QUEUE_DEPTH_DEF = 2;

	typedef enum logic [3:0] {
		PH_METHOD = 4'd0,
		PH_SEP1   = 4'd1,
		PH_URL    = 4'd2,
		PH_SEP2   = 4'd3,
		PH_PROTO  = 4'd4,
		PH_REST   = 4'd5,
		PH_HNAME  = 4'd6,
		PH_HCOLON = 4'd7,
		PH_HVALUE = 4'd8,
		PH_HBAD   = 4'd9
	} phase_t;

	// one classified input beat
	typedef struct packed {
		logic [7:0]           data;
		logic                 conn_end;
		logic                 is_cr;
		logic                 is_lf;
		logic                 is_space;
		logic                 is_colon;
		logic                 is_slash;
		logic [GET_LEN-1:0]   get_match;
		logic [PROTO_LEN-1:0] proto_match;
	} item_t;

endpackage

FILE: rtl/core/hrp_front.sv
module hrp_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	input  logic [7:0]    data_byte,
	input  logic          conn_end,
	output logic          q_valid,
	input  logic          q_stall,
	output hrp_pkg::item_t q_item
);
	import hrp_pkg::*;

	item_t cls;
	logic  valid_s1;
	item_t item_s1;

	// classify the incoming byte against all literal positions
	always_comb begin
		cls.data     = data_byte;
		cls.conn_end = conn_end;
		cls.is_cr    = (data_byte == CH_CR);
		cls.is_lf    = (data_byte == CH_LF);
		cls.is_space = (data_byte == CH_SPACE);
		cls.is_colon = (data_byte == CH_COLON);
		cls.is_slash = (data_byte == CH_SLASH);
		for (int i = 0; i < GET_LEN; i++) begin
			cls.get_match[i] = (data_byte == LIT_GET[i]);
		end
		for (int i = 0; i < PROTO_LEN; i++) begin
			cls.proto_match[i] = (data_byte == LIT_PROTO[i]);
		end
	end

	assign in_stall = valid_s1 && q_stall;

	// input stage register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			item_s1 <= cls;
		end
	end

	assign q_valid = valid_s1;
	assign q_item  = item_s1;

endmodule

FILE: rtl/core/hrp_queue.sv
module hrp_queue #(
	parameter int DEPTH = hrp_pkg::QUEUE_DEPTH_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr_valid,
	output logic           wr_stall,
	input  hrp_pkg::item_t wr_item,
	output logic           rd_valid,
	input  logic           rd_stall,
	output hrp_pkg::item_t rd_item
);
	import hrp_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	item_t            entry_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             push;
	logic             pop;

	assign wr_stall = (cnt_q == CNT_FULL);
	assign rd_valid = (cnt_q != '0);
	assign rd_item  = entry_q[rd_ptr_q];
	assign push     = wr_valid && !wr_stall;
	assign pop      = rd_valid && !rd_stall;

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= wr_item;
		end
	end

endmodule

FILE: rtl/core/hrp_back.sv
module hrp_back #(
	parameter int MAX_HEADERS = hrp_pkg::MAX_HEADERS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           q_valid,
	output logic           q_stall,
	input  hrp_pkg::item_t q_item,
	output logic           out_valid,
	input  logic           out_stall,
	output logic [7:0]     byte_out,
	output logic [2:0]     field_kind,
	output logic [6:0]     header_index,
	output logic           request_done,
	output logic           request_ok,
	output logic [2:0]     error_code,
	output logic [6:0]     header_total
);
	import hrp_pkg::*;

	localparam logic [HDR_W:0] MAX_HDR = (HDR_W+1)'(MAX_HEADERS);

	// parse state
	phase_t           phase_q,   n_phase;
	logic [3:0]       lit_q,     n_lit;
	logic             skip_q,    n_skip;
	logic             lstart_q,  n_lstart;
	logic [HDR_W-1:0] hdr_q,     n_hdr;
	logic [2:0]       ferr_q,    n_ferr;
	logic [2:0]       lerr_q,    n_lerr;

	// result of the beat in work
	logic [7:0]       r_byte;
	logic [2:0]       r_kind;
	logic [HDR_W-1:0] r_idx;
	logic             r_done;
	logic [2:0]       r_err;
	logic [HDR_W-1:0] r_total;

	logic             out_valid_q;
	logic             pop;

	assign q_stall = out_valid_q && out_stall;
	assign pop     = q_valid && !q_stall;

	function automatic logic [2:0] note(input logic [2:0] cur, input logic [2:0] code);
		note = (cur == ERR_NONE) ? code : cur;
	endfunction

	// next parse state and tagged result
	always_comb begin
		logic [2:0] le;
		logic       in_head;
		le       = lerr_q;
		in_head  = (phase_q > PH_REST);
		n_phase  = phase_q;
		n_lit    = lit_q;
		n_skip   = skip_q;
		n_lstart = lstart_q;
		n_hdr    = hdr_q;
		n_ferr   = ferr_q;
		n_lerr   = lerr_q;
		r_byte   = q_item.data;
		r_kind   = KIND_NONE;
		r_idx    = in_head ? hdr_q : '0;
		r_done   = 1'b0;
		r_err    = ERR_NONE;
		r_total  = '0;

		if (q_item.conn_end || (!skip_q && lstart_q && (q_item.is_cr || q_item.is_lf))) begin
			// end of request: verdict, then start over
			if (q_item.conn_end) begin
				r_byte = '0;
				r_idx  = '0;
			end
			r_done   = 1'b1;
			r_err    = in_head ? ferr_q : ERR_EMPTY;
			r_total  = hdr_q;
			n_phase  = PH_METHOD;
			n_lit    = '0;
			n_skip   = 1'b0;
			n_lstart = 1'b1;
			n_hdr    = '0;
			n_ferr   = ERR_NONE;
			n_lerr   = ERR_NONE;
		end else if (skip_q) begin
			n_skip = 1'b0;
		end else if (q_item.is_cr || q_item.is_lf) begin
			// line end: commit line error
			case (phase_q)
				PH_METHOD: begin
					if (lit_q != 4'(GET_LEN)) le = note(le, ERR_METHOD);
					le = note(le, ERR_URL);
				end
				PH_SEP1:  le = note(le, ERR_URL);
				PH_URL,
				PH_SEP2:  le = note(le, ERR_PROTOCOL);
				PH_PROTO: begin
					if (lit_q != 4'(PROTO_LEN)) le = note(le, ERR_PROTOCOL);
				end
				PH_REST: ;
				default: begin
					if (phase_q != PH_HVALUE) le = note(le, ERR_HLINE);
					if (({1'b0, hdr_q} >= MAX_HDR) || (hdr_q == HDR_SAT)) begin
						le = note(le, ERR_TOO_MANY);
					end
					if (hdr_q != HDR_SAT) n_hdr = hdr_q + 1'b1;
				end
			endcase
			if (ferr_q == ERR_NONE) n_ferr = le;
			n_lerr   = ERR_NONE;
			n_phase  = PH_HNAME;
			n_lit    = '0;
			n_lstart = 1'b1;
			n_skip   = q_item.is_cr;
		end else begin
			n_lstart = 1'b0;
			case (phase_q)
				PH_METHOD: begin
					if (q_item.is_space) begin
						if (lit_q != 4'(GET_LEN)) n_lerr = note(lerr_q, ERR_METHOD);
						n_phase = PH_SEP1;
					end else begin
						r_kind = KIND_METHOD;
						if (lit_q < 4'(GET_LEN) && q_item.get_match[lit_q[1:0]]) begin
							n_lit = lit_q + 1'b1;
						end else begin
							n_lerr = note(lerr_q, ERR_METHOD);
						end
					end
				end
				PH_SEP1: begin
					if (!q_item.is_space) begin
						r_kind = KIND_URL;
						if (!q_item.is_slash) n_lerr = note(lerr_q, ERR_URL);
						n_phase = PH_URL;
					end
				end
				PH_URL: begin
					if (q_item.is_space) n_phase = PH_SEP2;
					else r_kind = KIND_URL;
				end
				PH_SEP2: begin
					// first protocol byte, compared at position zero
					if (!q_item.is_space) begin
						r_kind  = KIND_PROTOCOL;
						n_phase = PH_PROTO;
						if (q_item.proto_match[0]) begin
							n_lit = 4'd1;
						end else begin
							n_lit  = '0;
							n_lerr = note(lerr_q, ERR_PROTOCOL);
						end
					end
				end
				PH_PROTO: begin
					if (q_item.is_space) begin
						if (lit_q != 4'(PROTO_LEN)) n_lerr = note(lerr_q, ERR_PROTOCOL);
						n_phase = PH_REST;
					end else begin
						r_kind = KIND_PROTOCOL;
						if (lit_q < 4'(PROTO_LEN) && q_item.proto_match[lit_q[2:0]]) begin
							n_lit = lit_q + 1'b1;
						end else begin
							n_lerr = note(lerr_q, ERR_PROTOCOL);
						end
					end
				end
				PH_HNAME: begin
					if (q_item.is_colon) n_phase = PH_HCOLON;
					else r_kind = KIND_HNAME;
				end
				PH_HCOLON: n_phase = q_item.is_space ? PH_HVALUE : PH_HBAD;
				PH_HVALUE: r_kind = KIND_HVALUE;
				default: ;
			endcase
		end
	end

	// parse state registers, advanced once per beat taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_METHOD;
			lit_q    <= '0;
			skip_q   <= 1'b0;
			lstart_q <= 1'b1;
			hdr_q    <= '0;
			ferr_q   <= ERR_NONE;
			lerr_q   <= ERR_NONE;
		end else if (pop) begin
			phase_q  <= n_phase;
			lit_q    <= n_lit;
			skip_q   <= n_skip;
			lstart_q <= n_lstart;
			hdr_q    <= n_hdr;
			ferr_q   <= n_ferr;
			lerr_q   <= n_lerr;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!q_stall) begin
			out_valid_q <= q_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			byte_out     <= r_byte;
			field_kind   <= r_kind;
			header_index <= r_idx;
			request_done <= r_done;
			request_ok   <= r_done && (r_err == ERR_NONE);
			error_code   <= r_err;
			header_total <= r_total;
		end
	end

	assign out_valid = out_valid_q;

endmodule

FILE: rtl/core/http_request_head_parser.sv
// HTTP request head parser.
// Input channel: in_valid / in_stall carry one beat per cycle, either a request
// byte on data_byte or a connection end flag on conn_end (byte ignored then).
// Output channel: out_valid / out_stall carry one tagged beat for every input
// beat: the byte, its field kind, header line index, and on the beat that ends
// the request the verdict (request_done, request_ok, error_code, header_total).
// Throughput is one beat per cycle while out_stall is low; the parse state updates once per beat.
// From input accept to out_valid a beat passes the input classify stage register,
// then the queue (QUEUE_DEPTH entries, two by default), then the parse stage,
// which loads its output register.
// When the receiver holds out_stall the output register holds its beat, the
// queue fills, and in_stall rises once the input stage has no room left.
// Reset (arst_n low) empties all stages and puts the parser at the start of
// a fresh request; after each finished request it starts over by itself.
module http_request_head_parser #(
	parameter int MAX_HEADERS = hrp_pkg::MAX_HEADERS_DEF,
	parameter int QUEUE_DEPTH = hrp_pkg::QUEUE_DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] data_byte,
	input  logic       conn_end,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] byte_out,
	output logic [2:0] field_kind,
	output logic [6:0] header_index,
	output logic       request_done,
	output logic       request_ok,
	output logic [2:0] error_code,
	output logic [6:0] header_total
);
	import hrp_pkg::*;

	logic  f_valid;
	logic  f_stall;
	item_t f_item;
	logic  b_valid;
	logic  b_stall;
	item_t b_item;

	// byte classification
	hrp_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.data_byte (data_byte),
		.conn_end  (conn_end),
		.q_valid   (f_valid),
		.q_stall   (f_stall),
		.q_item    (f_item)
	);

	// decoupling queue
	hrp_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (f_valid),
		.wr_stall (f_stall),
		.wr_item  (f_item),
		.rd_valid (b_valid),
		.rd_stall (b_stall),
		.rd_item  (b_item)
	);

	// parse state machine and output register
	hrp_back #(
		.MAX_HEADERS (MAX_HEADERS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_valid      (b_valid),
		.q_stall      (b_stall),
		.q_item       (b_item),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.byte_out     (byte_out),
		.field_kind   (field_kind),
		.header_index (header_index),
		.request_done (request_done),
		.request_ok   (request_ok),
		.error_code   (error_code),
		.header_total (header_total)
	);

endmodule
